/* hdl/cau_pkg.sv */
`timescale 1ns / 1ps
package cau_pkg;
  localparam int DW = 32;
  localparam int FB = 16;
  localparam int PW = 2 * DW;        // product width
  localparam int SW = PW + 1;        // sum of two products
  localparam int NW = PW + 1;        // squared magnitude
  localparam int QW = DW + 2;        // quotient bits kept
  localparam int QDEPTH = 4;
  localparam int QAW = 2;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
    logic b_zero;
  } item_t;

  typedef struct packed {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    logic ovf;
    logic dz;
  } res_t;

  // saturate signed value (neg flag, magnitude) to DW bits
  function automatic logic [DW:0] sat_mag(input logic neg, input logic [SW-1:0] mag);
    logic [DW:0] r;
    logic [SW-1:0] pmax;
    logic [SW-1:0] nmag;
    pmax = SW'((64'd1 << (DW - 1)) - 64'd1);
    nmag = SW'(64'd1 << (DW - 1));
    if (!neg) begin
      if (mag > pmax) r = {1'b1, pmax[DW-1:0]};
      else r = {1'b0, mag[DW-1:0]};
    end else begin
      if (mag > nmag) r = {1'b1, nmag[DW-1:0]};
      else r = {1'b0, DW'(-mag)};
    end
    return r;
  endfunction
endpackage

/* hdl/complex_arith_unit.sv */
`timescale 1ns / 1ps
// complex arithmetic unit, signed q16.16 operands
// input channel: one beat carries op code and operands a, b
//   op 0 add, 1 subtract, 2 multiply, 3 divide (a * conj(b) / |b|^2)
// output channel: one beat carries the result, overflow and divide-by-zero flags
// results saturate; a zero divisor gives zero and sets the divide-by-zero flag
// multiply and divide round toward minus infinity
// front end: zero-divisor check and a four-entry queue
// back end: product stage, sum stage, magnitude stage, then a restoring divider
//   of QW+FB (50) stages, one quotient bit each, then the output register
// throughput: one beat per cycle unless the receiver stalls; every op walks
// the same pipe, so order is kept
// reset (rst_n low, synchronous) empties the queue and the pipe
// when the receiver stalls the back pipe holds; the queue fills up to four beats
// and then in_tready drops
module complex_arith_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [135:0]  in_tdata,   // operation, a_re, a_im, b_re, b_im, pad
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [71:0]   out_tdata   // res_re, res_im, overflow, div_by_zero, pad
);
  cau_pkg::item_t in_item, q_item;
  cau_pkg::res_t  r_data;
  logic q_valid, q_ready;

  always_comb begin
    in_item.op     = in_tdata[1:0];
    in_item.a_re   = in_tdata[33:2];
    in_item.a_im   = in_tdata[65:34];
    in_item.b_re   = in_tdata[97:66];
    in_item.b_im   = in_tdata[129:98];
    in_item.b_zero = 1'b0;
  end

  cau_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_item(in_item),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  cau_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .r_valid(out_tvalid), .r_ready(out_tready), .r_data(r_data)
  );

  assign out_tdata = {6'd0, r_data.dz, r_data.ovf, r_data.im, r_data.re};

  // a divide-by-zero result never carries overflow
  a_dz_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[65] && out_tdata[64])) else $error("dz with overflow");
  // divide-by-zero result is zero
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[65]) |-> (out_tdata[63:0] == '0)) else $error("dz nonzero");
  // stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata))) else $error("hold");
endmodule

/* hdl/cau_front.sv */
`timescale 1ns / 1ps
module cau_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cau_pkg::item_t      in_item,
  output logic                q_valid,
  input  logic                q_ready,
  output cau_pkg::item_t      q_item
);
  cau_pkg::item_t mem_r [cau_pkg::QDEPTH];
  logic [cau_pkg::QAW-1:0] wp_r, rp_r;
  logic [cau_pkg::QAW:0] cnt_r;
  logic push, pop;
  cau_pkg::item_t cls;

  // classify: flag zero divisor up front
  always_comb begin
    cls = in_item;
    cls.b_zero = (in_item.b_re == '0) && (in_item.b_im == '0);
  end

  assign in_ready = cnt_r != (cau_pkg::QAW+1)'(cau_pkg::QDEPTH);
  assign q_valid = cnt_r != '0;
  assign q_item = mem_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cls;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (cau_pkg::QAW+1)'(push) - (cau_pkg::QAW+1)'(pop);
    end
  end
endmodule

/* hdl/cau_back.sv */
`timescale 1ns / 1ps
module cau_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  cau_pkg::item_t q_item,
  output logic           r_valid,
  input  logic           r_ready,
  output cau_pkg::res_t  r_data
);
  localparam int DW = cau_pkg::DW;
  localparam int SW = cau_pkg::SW;
  localparam int NW = cau_pkg::NW;
  localparam int QW = cau_pkg::QW;
  localparam int FB = cau_pkg::FB;
  localparam int DST = QW + FB;        // quotient bits developed, one per stage
  localparam int NS = DST + 3;         // stage registers before the output register
  localparam int QIW = $clog2(DST);

  typedef struct packed {
    logic [1:0] op;
    logic zero;
    logic neg_re, neg_im;
    logic [SW-1:0] mr, mi;          // magnitudes (or sums)
    logic [NW-1:0] den;
    logic [SW-1:0] rr, ri;          // remainders
    logic [DST-1:0] qr, qi;         // quotient bits
  } st_t;

  st_t s_r [NS];
  st_t s_nxt [NS];
  logic v_r [NS];
  logic adv;

  // whole pipe stalls when the output register is full and not taken
  logic out_v_r;
  cau_pkg::res_t out_r;
  assign adv = !out_v_r || r_ready;
  assign q_ready = adv;
  assign r_valid = out_v_r;
  assign r_data = out_r;

  // stage 0: four products and divisor magnitudes
  logic signed [2*DW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic [DW:0] ubr_r, ubi_r;
  // stage 1: squared divisor parts
  logic [NW-1:0] sqr_r, sqi_r;

  // divider scratch
  logic [QIW-1:0] bpos;
  logic [DST-1:0] dvr, dvi;
  logic [SW:0] tr, ti;

  always_comb begin
    // stage 0: capture op, zero flag, add and subtract sums
    s_nxt[0] = '0;
    s_nxt[0].op = q_item.op;
    s_nxt[0].zero = q_item.b_zero;
    s_nxt[0].mr = {{(SW-DW){q_item.a_re[DW-1]}}, q_item.a_re}
                + {{(SW-DW){q_item.b_re[DW-1]}}, q_item.b_re};
    s_nxt[0].mi = {{(SW-DW){q_item.a_im[DW-1]}}, q_item.a_im}
                + {{(SW-DW){q_item.b_im[DW-1]}}, q_item.b_im};
    s_nxt[0].rr = {{(SW-DW){q_item.a_re[DW-1]}}, q_item.a_re}
                - {{(SW-DW){q_item.b_re[DW-1]}}, q_item.b_re};
    s_nxt[0].ri = {{(SW-DW){q_item.a_im[DW-1]}}, q_item.a_im}
                - {{(SW-DW){q_item.b_im[DW-1]}}, q_item.b_im};

    // stage 1: sums of products
    s_nxt[1] = s_r[0];
    unique case (s_r[0].op)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: ;
      cau_pkg::OP_MUL: begin
        s_nxt[1].mr = SW'($signed(p_rr_r)) - SW'($signed(p_ii_r));
        s_nxt[1].mi = SW'($signed(p_ri_r)) + SW'($signed(p_ir_r));
      end
      default: begin
        s_nxt[1].mr = SW'($signed(p_rr_r)) + SW'($signed(p_ii_r));
        s_nxt[1].mi = SW'($signed(p_ir_r)) - SW'($signed(p_ri_r));
      end
    endcase

    // stage 2: den, magnitudes, signs; remainder starts with the dividend
    // bits above the developed quotient range
    s_nxt[2] = s_r[1];
    s_nxt[2].den = sqr_r + sqi_r;
    if (s_r[1].op == cau_pkg::OP_SUB) begin
      s_nxt[2].neg_re = s_r[1].rr[SW-1];
      s_nxt[2].neg_im = s_r[1].ri[SW-1];
      s_nxt[2].mr = s_r[1].rr[SW-1] ? -s_r[1].rr : s_r[1].rr;
      s_nxt[2].mi = s_r[1].ri[SW-1] ? -s_r[1].ri : s_r[1].ri;
    end else begin
      s_nxt[2].neg_re = s_r[1].mr[SW-1];
      s_nxt[2].neg_im = s_r[1].mi[SW-1];
      s_nxt[2].mr = s_r[1].mr[SW-1] ? -s_r[1].mr : s_r[1].mr;
      s_nxt[2].mi = s_r[1].mi[SW-1] ? -s_r[1].mi : s_r[1].mi;
    end
    s_nxt[2].rr = s_nxt[2].mr >> QW;
    s_nxt[2].ri = s_nxt[2].mi >> QW;
    s_nxt[2].qr = '0;
    s_nxt[2].qi = '0;

    // restoring divide: one quotient bit per stage over mag * 2^FB
    bpos = '0;
    dvr = '0;
    dvi = '0;
    tr = '0;
    ti = '0;
    for (int k = 0; k < DST; k++) begin
      bpos = QIW'(DST - 1 - k);
      dvr = {s_r[2+k].mr[QW-1:0], {FB{1'b0}}};
      dvi = {s_r[2+k].mi[QW-1:0], {FB{1'b0}}};
      tr = {s_r[2+k].rr, dvr[bpos]};
      ti = {s_r[2+k].ri, dvi[bpos]};
      s_nxt[3+k] = s_r[2+k];
      if (tr >= (SW+1)'(s_r[2+k].den)) begin
        s_nxt[3+k].rr = SW'(tr - (SW+1)'(s_r[2+k].den));
        s_nxt[3+k].qr = {s_r[2+k].qr[DST-2:0], 1'b1};
      end else begin
        s_nxt[3+k].rr = SW'(tr);
        s_nxt[3+k].qr = {s_r[2+k].qr[DST-2:0], 1'b0};
      end
      if (ti >= (SW+1)'(s_r[2+k].den)) begin
        s_nxt[3+k].ri = SW'(ti - (SW+1)'(s_r[2+k].den));
        s_nxt[3+k].qi = {s_r[2+k].qi[DST-2:0], 1'b1};
      end else begin
        s_nxt[3+k].ri = SW'(ti);
        s_nxt[3+k].qi = {s_r[2+k].qi[DST-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_rr_r <= q_item.a_re * q_item.b_re;
      p_ii_r <= q_item.a_im * q_item.b_im;
      p_ri_r <= q_item.a_re * q_item.b_im;
      p_ir_r <= q_item.a_im * q_item.b_re;
      ubr_r <= q_item.b_re[DW-1] ? (DW+1)'(-$signed({q_item.b_re[DW-1], q_item.b_re}))
                                 : {1'b0, q_item.b_re};
      ubi_r <= q_item.b_im[DW-1] ? (DW+1)'(-$signed({q_item.b_im[DW-1], q_item.b_im}))
                                 : {1'b0, q_item.b_im};
      sqr_r <= {{(NW-DW-1){1'b0}}, ubr_r} * {{(NW-DW-1){1'b0}}, ubr_r};
      sqi_r <= {{(NW-DW-1){1'b0}}, ubi_r} * {{(NW-DW-1){1'b0}}, ubi_r};
      for (int k = 0; k < NS; k++) s_r[k] <= s_nxt[k];
    end
  end

  // final: round, saturate
  st_t fz;
  logic hr, hi;
  logic [SW-1:0] er, ei;
  logic [DW:0] sr_o, si_o;
  cau_pkg::res_t res;
  always_comb begin
    fz = s_r[NS-1];
    // dividend bits above the developed range at or over den: quotient is huge
    hr = (fz.mr >> QW) >= fz.den;
    hi = (fz.mi >> QW) >= fz.den;
    er = '0;
    ei = '0;
    unique case (fz.op)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        er = fz.mr;
        ei = fz.mi;
      end
      cau_pkg::OP_MUL: begin
        er = (fz.mr >> FB) + SW'(fz.neg_re && (fz.mr[FB-1:0] != '0));
        ei = (fz.mi >> FB) + SW'(fz.neg_im && (fz.mi[FB-1:0] != '0));
      end
      default: begin
        er = hr ? '1 : SW'(fz.qr) + SW'(fz.neg_re && fz.rr != '0);
        ei = hi ? '1 : SW'(fz.qi) + SW'(fz.neg_im && fz.ri != '0);
      end
    endcase
    sr_o = cau_pkg::sat_mag(fz.neg_re, er);
    si_o = cau_pkg::sat_mag(fz.neg_im, ei);
    res.re = sr_o[DW-1:0];
    res.im = si_o[DW-1:0];
    res.ovf = sr_o[DW] | si_o[DW];
    res.dz = 1'b0;
    if (fz.op == cau_pkg::OP_DIV && fz.zero) begin
      res = '0;
      res.dz = 1'b1;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) v_r[k] <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      v_r[0] <= q_valid;
      for (int k = 1; k < NS; k++) v_r[k] <= v_r[k-1];
      out_v_r <= v_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_r <= res;
  end
endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic ovf;
    logic dz;
  } cplx_res_t;

  // queue of expected results plus mismatch bookkeeping
  class cplx_scoreboard;
    cplx_res_t pending[$];
    int errors;
    int checked;

    function void note_input(cplx_res_t r);
      pending.push_back(r);
    endfunction

    function void check_result(logic [71:0] d);
      cplx_res_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", d);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (d[31:0] !== e.re || d[63:32] !== e.im || d[64] !== e.ovf || d[65] !== e.dz) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp re %h im %h ov %b dz %b, got re %h im %h ov %b dz %b",
                   e.re, e.im, e.ovf, e.dz, d[31:0], d[63:32], d[64], d[65]);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [135:0] in_tdata;   // operation, a_re, a_im, b_re, b_im, pad
  logic out_tvalid;
  logic out_tready;
  logic [71:0] out_tdata;   // res_re, res_im, overflow, div_by_zero, pad

  cplx_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int idle_cycles;
  int n_sent;
  bit timed_out;

  complex_arith_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // saturate an exact signed value to 32 bits
  function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic ov);
    if (v > 128'sd2147483647) begin
      ov = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -128'sd2147483648) begin
      ov = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  // floor division of a signed numerator by a positive denominator
  function automatic logic signed [127:0] floor_div(input logic signed [127:0] n,
                                                    input logic signed [127:0] d);
    logic signed [127:0] q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic cplx_res_t predict_cplx(input logic [1:0] op,
      input logic signed [31:0] ar, input logic signed [31:0] ai,
      input logic signed [31:0] br, input logic signed [31:0] bi);
    cplx_res_t r;
    logic signed [127:0] xr, xi, den, nr, ni;
    r.ovf = 1'b0;
    r.dz = 1'b0;
    r.re = '0;
    r.im = '0;
    xr = 128'(ar);
    xi = 128'(ai);
    case (op)
      cau_pkg::OP_ADD: begin
        r.re = clamp32(xr + 128'(br), r.ovf);
        r.im = clamp32(xi + 128'(bi), r.ovf);
      end
      cau_pkg::OP_SUB: begin
        r.re = clamp32(xr - 128'(br), r.ovf);
        r.im = clamp32(xi - 128'(bi), r.ovf);
      end
      cau_pkg::OP_MUL: begin
        r.re = clamp32((xr * br - xi * bi) >>> cau_pkg::FB, r.ovf);
        r.im = clamp32((xr * bi + xi * br) >>> cau_pkg::FB, r.ovf);
      end
      default: begin
        if (br == 0 && bi == 0) r.dz = 1'b1;
        else begin
          den = 128'(br) * br + 128'(bi) * bi;
          nr = (xr * br + xi * bi) <<< cau_pkg::FB;
          ni = (xi * br - xr * bi) <<< cau_pkg::FB;
          r.re = clamp32(floor_div(nr, den), r.ovf);
          r.im = clamp32(floor_div(ni, den), r.ovf);
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      3: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
      4: return '0;
      default: return $urandom;
    endcase
  endfunction

  // one input beat: random idle gaps, then hold valid until accepted
  task automatic send_beat(input logic [1:0] op, input logic [31:0] ar, input logic [31:0] ai,
                           input logic [31:0] br, input logic [31:0] bi);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {(6)'(0), bi, br, ai, ar, op};
    sb.note_input(predict_cplx(op, ar, ai, br, bi));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_sent++;
  endtask

  task automatic send_random(input int count);
    logic [1:0] op;
    repeat (count) begin
      op = 2'($urandom_range(0, 3));
      if (op == cau_pkg::OP_DIV && $urandom_range(0, 15) == 0)
        send_beat(op, rand_operand(), rand_operand(), '0, '0);
      else
        send_beat(op, rand_operand(), rand_operand(), rand_operand(), rand_operand());
    end
  endtask

  // receiver: random stalls, results checked as they are accepted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("** complex_arith_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [1:0] op;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    idle_cycles = 0;
    n_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every op against field extremes, plus a zero divisor
    for (int k = 0; k < 4; k++) begin
      op = 2'(k);
      send_beat(op, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      send_beat(op, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
      send_beat(op, 32'h00010000, 32'hffff0000, 32'h00020000, 32'h00008000);
      send_beat(op, 32'h80000000, 32'h7fffffff, 32'h00000001, 32'hffffffff);
      send_beat(op, 32'h12345678, 32'hfedcba98, 32'h0, 32'h0);
    end

    // random part across idling phases
    send_idle_pct = 0;  recv_stall_pct = 0;  send_random(320);
    send_idle_pct = 62; recv_stall_pct = 0;  send_random(310);
    send_idle_pct = 0;  recv_stall_pct = 62; send_random(310);
    send_idle_pct = 29; recv_stall_pct = 29; send_random(310);
    in_tvalid <= 1'b0;

    recv_stall_pct = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("covered %0d operand beats over add, subtract, multiply, divide", n_sent);
    $display("checked %0d results, saturation and zero divisor included", sb.checked);
    if (sb.errors == 0) $display("** complex_arith_unit: PASSED **");
    else $display("** complex_arith_unit: FAILED **");
    $finish;
  end
endmodule
